### rtl/bsfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsfe_pkg;

	localparam int unsigned MSG_BYTES_DEF = 16;
	localparam int unsigned CMD_DEPTH     = 4;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned STEP_W        = 3;
	localparam int unsigned STEPS         = 8;

	localparam logic [BYTE_W-1:0] HEAD_RST   = 8'd2;
	localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd16;
	localparam logic [BYTE_W-1:0] TAIL_RST   = 8'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] head_value;
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] tail_value;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              data_esc;
		logic              first;
		logic              last;
		logic [BYTE_W-1:0] sum;
		logic              sum_esc;
	} cmd_t;

	typedef enum logic [STEP_W-1:0] {
		STEP_HEAD0,
		STEP_HEAD1,
		STEP_DATA_ESC,
		STEP_DATA,
		STEP_SUM_ESC,
		STEP_SUM,
		STEP_TAIL0,
		STEP_TAIL1
	} step_t;

	function automatic logic is_reserved(logic [BYTE_W-1:0] b, cfg_t c);
		return (b == c.head_value) || (b == c.escape_value) || (b == c.tail_value);
	endfunction

	function automatic logic [STEPS-1:0] step_mask(cmd_t c);
		logic [STEPS-1:0] m;
		m                = '0;
		m[STEP_HEAD0]    = c.first;
		m[STEP_HEAD1]    = c.first;
		m[STEP_DATA_ESC] = c.data_esc;
		m[STEP_DATA]     = 1'b1;
		m[STEP_SUM_ESC]  = c.last & c.sum_esc;
		m[STEP_SUM]      = c.last;
		m[STEP_TAIL0]    = c.last;
		m[STEP_TAIL1]    = c.last;
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/bsfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bsfe_front #(
	parameter int unsigned MSG_BYTES = bsfe_pkg::MSG_BYTES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic                                 q_full,
	output logic                                      full,
	output logic                                      cmd_wr,
	output bsfe_pkg::cmd_t                            cmd,
	input  wire logic                                 cfg_valid,
	input  wire logic [bsfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]          cfg_data,
	output logic                                      cfg_ready,
	output bsfe_pkg::cfg_t                            cfg
);

	localparam int unsigned POS_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(MSG_BYTES - 1);

	logic [POS_W-1:0]            pos_q;
	logic [bsfe_pkg::BYTE_W-1:0] sum_q;
	bsfe_pkg::cfg_t              cfg_q;
	logic [bsfe_pkg::BYTE_W-1:0] sum_nx;
	logic                        first;
	logic                        last;

	assign full      = q_full;
	assign cmd_wr    = push & ~q_full;
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	assign sum_nx = sum_q + data_byte;
	assign first  = (pos_q == '0);
	assign last   = (pos_q == LAST_POS);

	always_comb begin
		cmd          = '0;
		cmd.data     = data_byte;
		cmd.data_esc = bsfe_pkg::is_reserved(data_byte, cfg_q);
		cmd.first    = first;
		cmd.last     = last;
		cmd.sum      = sum_nx;
		cmd.sum_esc  = bsfe_pkg::is_reserved(sum_nx, cfg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (cmd_wr) begin
			if (last) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_value   <= bsfe_pkg::HEAD_RST;
			cfg_q.escape_value <= bsfe_pkg::ESCAPE_RST;
			cfg_q.tail_value   <= bsfe_pkg::TAIL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsfe_pkg::REG_HEAD:   cfg_q.head_value   <= cfg_data;
				bsfe_pkg::REG_ESCAPE: cfg_q.escape_value <= cfg_data;
				bsfe_pkg::REG_TAIL:   cfg_q.tail_value   <= cfg_data;
				default: ;
			endcase
		end
	end

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr && last |=> (pos_q == '0) && (sum_q == '0))
		else $error("frame state not cleared after last byte");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond message length");

endmodule
`default_nettype wire

### rtl/bsfe_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bsfe_cmd_queue #(
	parameter int unsigned DEPTH = bsfe_pkg::CMD_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  bsfe_pkg::cmd_t wdata,
	output logic          full,
	input  wire logic     rd,
	output bsfe_pkg::cmd_t rdata,
	output logic          empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	bsfe_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr |-> !full) and (rd |-> !empty))
		else $error("command queue overrun or underrun");

endmodule
`default_nettype wire

### rtl/bsfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bsfe_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  bsfe_pkg::cfg_t                   cfg,
	input  wire logic                        q_empty,
	input  bsfe_pkg::cmd_t                   q_rdata,
	output logic                             q_rd,
	input  wire logic                        pop,
	output logic                             empty,
	output logic [bsfe_pkg::BYTE_W-1:0]      out_byte,
	output logic                             run_last,
	output logic                             frame_end
);

	logic [bsfe_pkg::STEPS-1:0]  mask_q;
	bsfe_pkg::cmd_t              cur_q;
	logic                        out_vld_q;
	logic [bsfe_pkg::BYTE_W-1:0] out_byte_q;
	logic                        run_last_q;
	logic                        frame_end_q;

	logic                        out_rdy;
	logic                        emit;
	logic [bsfe_pkg::STEPS-1:0]  sel;
	logic [bsfe_pkg::STEPS-1:0]  rest;
	bsfe_pkg::step_t             step;
	logic [bsfe_pkg::BYTE_W-1:0] byte_nx;

	assign out_rdy = ~out_vld_q | pop;
	assign emit    = (mask_q != '0) & out_rdy;
	assign sel     = mask_q & (~mask_q + 1'b1);
	assign rest    = mask_q & ~sel;
	assign q_rd    = ~q_empty & ((mask_q == '0) | (emit & (rest == '0)));

	always_comb begin
		step = bsfe_pkg::STEP_DATA;
		for (int i = bsfe_pkg::STEPS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				step = bsfe_pkg::step_t'(bsfe_pkg::STEP_W'(i));
			end
		end
	end

	always_comb begin
		case (step)
			bsfe_pkg::STEP_HEAD0,
			bsfe_pkg::STEP_HEAD1:    byte_nx = cfg.head_value;
			bsfe_pkg::STEP_DATA_ESC,
			bsfe_pkg::STEP_SUM_ESC:  byte_nx = cfg.escape_value;
			bsfe_pkg::STEP_DATA:     byte_nx = cur_q.data;
			bsfe_pkg::STEP_SUM:      byte_nx = cur_q.sum;
			bsfe_pkg::STEP_TAIL0,
			bsfe_pkg::STEP_TAIL1:    byte_nx = cfg.tail_value;
			default:                 byte_nx = cur_q.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_rd) begin
				mask_q <= bsfe_pkg::step_mask(q_rdata);
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_rdata;
		end
		if (emit) begin
			out_byte_q  <= byte_nx;
			run_last_q  <= (rest == '0);
			frame_end_q <= (step == bsfe_pkg::STEP_TAIL1);
		end
	end

	assign empty     = ~out_vld_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && frame_end_q |-> run_last_q)
		else $error("frame end not on last byte of its item");

	a_tail_order: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[bsfe_pkg::STEP_TAIL0] |-> mask_q[bsfe_pkg::STEP_TAIL1]
			&& mask_q[bsfe_pkg::STEP_SUM] == mask_q[bsfe_pkg::STEP_SUM_ESC]
				|| mask_q[bsfe_pkg::STEP_SUM])
		else $error("tail pending without second tail");

endmodule
`default_nettype wire

### rtl/byte_stuff_frame_encoder.sv
// An accepted item is written to the command queue, loaded into the back-end
// sequencer and then registered at the output. Throughput: one framed byte per
// cycle while the receiver pops; an item yields 1 to 8 framed bytes. A new
// item is taken every cycle while the 4-entry command queue has room.
// Reset (arst_n low) clears frame position, checksum, queue and output; the
// markers return to head 2, escape 16, tail 3.
`timescale 1ns / 1ps
`default_nettype none
module byte_stuff_frame_encoder #(
	parameter int unsigned MSG_BYTES = bsfe_pkg::MSG_BYTES_DEF,
	parameter int unsigned CMD_DEPTH = bsfe_pkg::CMD_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]    data_byte,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [bsfe_pkg::BYTE_W-1:0]         out_byte,
	output logic                                run_last,
	output logic                                frame_end,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bsfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bsfe_pkg::BYTE_W-1:0]    cfg_data
);

	bsfe_pkg::cfg_t cfg;
	bsfe_pkg::cmd_t cmd;
	bsfe_pkg::cmd_t q_rdata;
	logic           cmd_wr;
	logic           q_full;
	logic           q_empty;
	logic           q_rd;

	bsfe_front #(
		.MSG_BYTES (MSG_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.q_full    (q_full),
		.full      (full),
		.cmd_wr    (cmd_wr),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	bsfe_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	bsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire

### tb/byte_stuff_frame_encoder_checker.sv
`timescale 1ns / 1ps
module byte_stuff_frame_encoder_checker #(
	parameter int unsigned MSG_BYTES = bsfe_pkg::MSG_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic [bsfe_pkg::BYTE_W-1:0]    data_byte,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [bsfe_pkg::BYTE_W-1:0]    out_byte,
	input  logic                           run_last,
	input  logic                           frame_end,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bsfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsfe_pkg::BYTE_W-1:0]    cfg_data,
	output int unsigned                    outstanding,
	output int unsigned                    mismatches
);
	import bsfe_pkg::*;

	localparam int unsigned FRAME_LEN = (MSG_BYTES < 1) ? 1 : MSG_BYTES;

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              run_last;
		logic              frame_end;
	} framed_byte_t;

	framed_byte_t      framed_q[$];
	cfg_t              markers;
	int unsigned       msg_pos;
	logic [BYTE_W-1:0] msg_sum;

	function automatic void queue_byte(logic [BYTE_W-1:0] v, logic fe);
		framed_byte_t fb;
		fb.value     = v;
		fb.run_last  = 1'b0;
		fb.frame_end = fe;
		framed_q.push_back(fb);
	endfunction

	function automatic void queue_stuffed(logic [BYTE_W-1:0] v);
		if (v == markers.head_value || v == markers.escape_value || v == markers.tail_value)
			queue_byte(markers.escape_value, 1'b0);
		queue_byte(v, 1'b0);
	endfunction

	function automatic void frame_data_byte(logic [BYTE_W-1:0] b);
		if (msg_pos == 0) begin
			queue_byte(markers.head_value, 1'b0);
			queue_byte(markers.head_value, 1'b0);
		end
		queue_stuffed(b);
		msg_sum = msg_sum + b;
		if (msg_pos + 1 >= FRAME_LEN) begin
			queue_stuffed(msg_sum);
			queue_byte(markers.tail_value, 1'b0);
			queue_byte(markers.tail_value, 1'b1);
			msg_pos = 0;
			msg_sum = '0;
		end else begin
			msg_pos++;
		end
		framed_q[framed_q.size() - 1].run_last = 1'b1;
	endfunction

	function automatic void check_framed_byte();
		framed_byte_t want;
		if (framed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected item: byte %h last %b end %b",
					$time, out_byte, run_last, frame_end);
		end else begin
			want = framed_q.pop_front();
			if (want.value !== out_byte || want.run_last !== run_last ||
					want.frame_end !== frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected byte %h last %b end %b, got byte %h last %b end %b",
						$time, want.value, want.run_last, want.frame_end,
						out_byte, run_last, frame_end);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framed_q.delete();
			msg_pos = 0;
			msg_sum = '0;
			markers.head_value   = HEAD_RST;
			markers.escape_value = ESCAPE_RST;
			markers.tail_value   = TAIL_RST;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HEAD:   markers.head_value   = cfg_data;
					REG_ESCAPE: markers.escape_value = cfg_data;
					REG_TAIL:   markers.tail_value   = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty)
				check_framed_byte();
			if (push && !full)
				frame_data_byte(data_byte);
			outstanding <= framed_q.size();
		end
	end

endmodule

### tb/byte_stuff_frame_encoder_tb.sv
`timescale 1ns / 1ps
module byte_stuff_frame_encoder_tb;
	import bsfe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned HOLD_CYCLES = 80;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 run_last;
	logic                 frame_end;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_data  = '0;

	int unsigned outstanding;
	int unsigned mismatches;
	int unsigned idle_cycles = 0;
	int unsigned hold_left   = 0;
	bit          calm        = 1'b0;
	bit          hold_req    = 1'b0;
	bit          hold_done   = 1'b0;

	logic [BYTE_W-1:0] head_v = HEAD_RST;
	logic [BYTE_W-1:0] esc_v  = ESCAPE_RST;
	logic [BYTE_W-1:0] tail_v = TAIL_RST;
	int unsigned       frame_pos = 0;
	logic [BYTE_W-1:0] frame_sum = '0;

	always #5 clk = ~clk;

	byte_stuff_frame_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	byte_stuff_frame_encoder_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	function automatic logic [BYTE_W-1:0] marker_of(int unsigned k);
		case (k)
			0:       return head_v;
			1:       return esc_v;
			default: return tail_v;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_marker();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic [BYTE_W-1:0] b);
		if (!calm && $urandom_range(0, 99) < 10) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		frame_sum = frame_sum + b;
		if (frame_pos == MSG_BYTES_DEF - 1) begin
			frame_pos = 0;
			frame_sum = '0;
		end else
			frame_pos++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HEAD:   head_v = val;
			REG_ESCAPE: esc_v  = val;
			REG_TAIL:   tail_v = val;
			default: ;
		endcase
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] directed_bytes[15];
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] low_bytes[5];
		int unsigned       n;
		int unsigned       r;

		directed_bytes = '{8'h00, 8'hFF, HEAD_RST, ESCAPE_RST, TAIL_RST, 8'h01, 8'h80,
			8'h7F, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h11, 8'h04, 8'h12};
		low_bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h7E};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default markers; checksum lands on the escape value
		foreach (directed_bytes[i])
			send_item(directed_bytes[i]);
		send_item(esc_v - frame_sum);
		push <= 1'b0;

		// coinciding head and escape, tail at zero, stray index ignored
		write_reg(REG_HEAD, 8'hFF);
		write_reg(REG_ESCAPE, 8'hFF);
		write_reg(REG_TAIL, 8'h00);
		write_reg(REG_NONE, 8'h5A);
		foreach (low_bytes[i])
			send_item(low_bytes[i]);
		push <= 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_HEAD, pick_marker());
			write_reg(REG_ESCAPE, ($urandom_range(0, 3) == 0) ? head_v : pick_marker());
			write_reg(REG_TAIL, ($urandom_range(0, 3) == 0) ? esc_v : pick_marker());
			if (ph == 3)
				write_reg(REG_NONE, BYTE_W'($urandom_range(0, 255)));
			calm = (ph == 2);
			n = (ph == 4) ? 30 : $urandom_range(18, 32);
			if (ph == 4)
				hold_req = 1'b1;
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (frame_pos == MSG_BYTES_DEF - 1 && r < 40)
					b = marker_of($urandom_range(0, 2)) - frame_sum;
				else if (r < 30)
					b = marker_of($urandom_range(0, 2));
				else
					b = BYTE_W'($urandom_range(0, 255));
				send_item(b);
			end
			push <= 1'b0;
			calm = 1'b0;
		end

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
